FILE: design/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, register indexes and modular helpers for the RSA modexp core.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int unsigned ModWidth  = 32;
  localparam int unsigned ExpWidth  = 32;
  localparam int unsigned CfgIdxW   = 2;
  // one pipeline stage per multiplier bit, one group per exponent bit
  localparam int unsigned MulSteps  = ModWidth;
  localparam int unsigned ExpStages = ExpWidth * MulSteps;

  localparam logic [ModWidth-1:0] ModulusRst = ModWidth'(3233);
  localparam logic [ExpWidth-1:0] PubExpRst  = ExpWidth'(17);
  localparam logic [ExpWidth-1:0] PrivExpRst = ExpWidth'(2753);

  typedef enum logic [CfgIdxW-1:0] {
    CfgModulus  = 2'd0,
    CfgPubExp   = 2'd1,
    CfgPrivExp  = 2'd2,
    CfgReserved = 2'd3
  } cfg_idx_e;

  // message reduction word
  typedef struct packed {
    logic                valid;
    logic                act;
    logic [ModWidth-1:0] msg;
    logic [ModWidth-1:0] rem;
  } red_t;

  // square-and-multiply word
  typedef struct packed {
    logic                valid;
    logic                act;
    logic [ModWidth-1:0] acc;
    logic [ModWidth-1:0] prod_m;
    logic [ModWidth-1:0] prod_s;
    logic [ModWidth-1:0] add_m;
    logic [ModWidth-1:0] add_s;
    logic [ModWidth-1:0] mult;
  } mst_t;

  // (a + b) mod n for a, b below n
  function automatic logic [ModWidth-1:0] add_mod(input logic [ModWidth-1:0] a,
                                                  input logic [ModWidth-1:0] b,
                                                  input logic [ModWidth-1:0] n);
    logic [ModWidth:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, n}) begin
      sum = sum - {1'b0, n};
    end
    return sum[ModWidth-1:0];
  endfunction

  // one double-and-add step on both products
  function automatic mst_t mul_step(input mst_t w, input logic [ModWidth-1:0] n);
    mst_t o;
    o = w;
    if (w.mult[0]) begin
      o.prod_m = add_mod(w.prod_m, w.add_m, n);
      o.prod_s = add_mod(w.prod_s, w.add_s, n);
    end
    o.add_m = add_mod(w.add_m, w.add_m, n);
    o.add_s = add_mod(w.add_s, w.add_s, n);
    o.mult  = w.mult >> 1;
    return o;
  endfunction

endpackage

FILE: design/rsa_modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_core
// Pipelined message^exponent mod modulus with key values in config registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | action_i, message_i
//  out     | output    | out_valid_o / out_ready_i | result_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one word enters per cycle while the output is not stalled; the pipe is 32 stages
// of restoring reduction of the message, 32 double-and-add stages for each of the 32
// exponent bits, and the output register.
// reset clears all valid bits and loads the default key.
// the whole pipe holds while the output word waits to be taken.
module rsa_modular_exponentiation_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [rme_pkg::ModWidth-1:0]       message_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rme_pkg::ModWidth-1:0]       result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rme_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rme_pkg::ModWidth-1:0]       cfg_data_i
);

  localparam int unsigned W  = rme_pkg::ModWidth;
  localparam int unsigned NS = rme_pkg::ExpStages;
  localparam int unsigned MS = rme_pkg::MulSteps;

  logic [W-1:0]                  modulus_q;
  logic [rme_pkg::ExpWidth-1:0]  pub_exp_q, priv_exp_q;
  logic                          en;
  logic                          out_valid_q;
  logic [W-1:0]                  result_q;
  logic [W-1:0]                  result_d;
  logic [rme_pkg::ExpWidth-1:0]  last_exp;

  rme_pkg::red_t red_q [W];
  rme_pkg::red_t red_d [W];
  rme_pkg::mst_t mst_q [NS];
  rme_pkg::mst_t mst_d [NS];

  assign cfg_ready_o = 1'b1;
  assign en          = ~(out_valid_q & ~out_ready_i);
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= rme_pkg::ModulusRst;
      pub_exp_q  <= rme_pkg::PubExpRst;
      priv_exp_q <= rme_pkg::PrivExpRst;
    end else if (cfg_valid_i) begin
      unique case (rme_pkg::cfg_idx_e'(cfg_index_i))
        rme_pkg::CfgModulus:  modulus_q  <= cfg_data_i;
        rme_pkg::CfgPubExp:   pub_exp_q  <= cfg_data_i;
        rme_pkg::CfgPrivExp:  priv_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // message reduction, one quotient bit a stage
  for (genvar k = 0; k < W; k++) begin : g_red
    localparam int unsigned KP = (k == 0) ? 0 : k - 1;
    always_comb begin
      rme_pkg::red_t src;
      logic [W:0]    tmp;
      if (k == 0) begin
        src.valid = in_valid_i;
        src.act   = action_i;
        src.msg   = message_i;
        src.rem   = '0;
      end else begin
        src = red_q[KP];
      end
      tmp = {src.rem, src.msg[W-1]};
      if (tmp >= {1'b0, modulus_q}) begin
        tmp = tmp - {1'b0, modulus_q};
      end
      red_d[k]       = src;
      red_d[k].rem   = tmp[W-1:0];
      red_d[k].msg   = src.msg << 1;
    end
  end

  // square-and-multiply, one multiplier bit a stage
  for (genvar t = 0; t < NS; t++) begin : g_mst
    localparam int unsigned J  = t / MS;
    localparam int unsigned S  = t % MS;
    localparam int unsigned JB = (J == 0) ? 0 : J - 1;
    localparam int unsigned TP = (t == 0) ? 0 : t - 1;
    always_comb begin
      rme_pkg::mst_t src;
      logic [W-1:0]  acc_n;
      logic [W-1:0]  exp_w;
      if (t == 0) begin
        src.valid  = red_q[W-1].valid;
        src.act    = red_q[W-1].act;
        src.acc    = W'(1);
        src.prod_m = '0;
        src.prod_s = '0;
        src.add_m  = W'(1);
        src.add_s  = red_q[W-1].rem;
        src.mult   = red_q[W-1].rem;
        acc_n      = '0;
        exp_w      = '0;
      end else if (S == 0) begin
        // close the previous exponent bit and start the next products
        src   = mst_q[TP];
        exp_w = src.act ? priv_exp_q : pub_exp_q;
        acc_n = exp_w[JB] ? src.prod_m : src.acc;
        src.acc    = acc_n;
        src.add_m  = acc_n;
        src.add_s  = src.prod_s;
        src.mult   = src.prod_s;
        src.prod_m = '0;
        src.prod_s = '0;
      end else begin
        src   = mst_q[TP];
        acc_n = '0;
        exp_w = '0;
      end
      mst_d[t] = rme_pkg::mul_step(src, modulus_q);
    end
  end

  always_comb begin
    last_exp = mst_q[NS-1].act ? priv_exp_q : pub_exp_q;
    // modulus one (or zero) always gives zero
    if (modulus_q < W'(2)) begin
      result_d = '0;
    end else begin
      result_d = last_exp[rme_pkg::ExpWidth-1] ? mst_q[NS-1].prod_m : mst_q[NS-1].acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < W; i++) begin
        red_q[i] <= '0;
      end
      for (int i = 0; i < NS; i++) begin
        mst_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else if (en) begin
      for (int i = 0; i < W; i++) begin
        red_q[i] <= red_d[i];
      end
      for (int i = 0; i < NS; i++) begin
        mst_q[i] <= mst_d[i];
      end
      out_valid_q <= mst_q[NS-1].valid;
      result_q    <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: design/rme_checker.sv
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks on the RSA modexp core, bound to the top level.
// ----------------------------------------------------------------------------
module rme_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [rme_pkg::ModWidth-1:0]  result_o,
  input logic                          cfg_ready_o
);

  // a waiting output word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("output word dropped or changed while stalled");

  // input side only stalls behind a blocked output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // input flows whenever the output is taken
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output is free");

  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind rsa_modular_exponentiation_core rme_checker u_rme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o),
  .cfg_ready_o (cfg_ready_o)
);
